FILE: rtl/baa_pkg.sv
// Package for the ballistic aim angle core.
// Holds the datapath widths, the drop constants and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package baa_pkg;

   localparam int PosW = 17;
   localparam int SpdW = 14;
   localparam int OffW = 14;
   localparam int AngW = 17;

   localparam int ZmW = 16;
   localparam int Z2W = 32;
   localparam int S2W = 28;
   localparam int NumW = 48;
   localparam int DenW = 36;
   localparam int QuoW = 37;
   localparam int YpW = 38;
   localparam int MagW = 37;
   localparam int NrmW = 30;
   localparam int KW = 3;
   localparam int LenW = 6;
   localparam int YsqW = 60;
   localparam int R2W = 61;
   localparam int RadW = 62;
   localparam int RootW = 31;
   localparam int SqRemW = 33;
   localparam int CxW = 33;
   localparam int CaW = 25;

   localparam int CordicStepsDef = 16;
   localparam int CordicStepsMax = 32;

   localparam int DropNumK = 50176;
   localparam int DropDenK = 250;
   localparam int DropBiasK = 125;
   localparam int SlowSpd = 2;
   localparam int RoundBias = 128;
   localparam int RoundShift = 8;

   localparam logic signed [CaW-1:0] AngMax = 25'sd5898240;

   localparam logic [CaW-1:0] AtanTab [CordicStepsMax] = '{
      25'd2949120, 25'd1740967, 25'd919879, 25'd466945,
      25'd234379, 25'd117304, 25'd58666, 25'd29335,
      25'd14668, 25'd7334, 25'd3667, 25'd1833,
      25'd917, 25'd458, 25'd229, 25'd115,
      25'd57, 25'd29, 25'd14, 25'd7,
      25'd4, 25'd2, 25'd1, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0,
      25'd0, 25'd0, 25'd0, 25'd0
   };

endpackage

FILE: rtl/baa_div_cell.sv
// One restoring division cell: yields one quotient bit per cycle while en is high.
// Depends on baa_pkg.
`timescale 1ns / 1ps

module baa_div_cell
   import baa_pkg::*;
#(
   parameter int PW = 1
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [DenW-1:0] in_rem,
   input  logic [DenW-1:0] in_den,
   input  logic [QuoW-1:0] in_num,
   input  logic [QuoW-1:0] in_quo,
   input  logic [PW-1:0]   in_pay,
   output logic            out_valid,
   output logic [DenW-1:0] out_rem,
   output logic [DenW-1:0] out_den,
   output logic [QuoW-1:0] out_num,
   output logic [QuoW-1:0] out_quo,
   output logic [PW-1:0]   out_pay
);

   logic            valid_ff;
   logic [DenW-1:0] rem_ff, rem_in, den_ff;
   logic [QuoW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [PW-1:0]   pay_ff;
   logic [DenW:0]   trial, diff;
   logic            ge;

   always_comb begin
      trial  = {in_rem, in_num[QuoW-1]};
      ge     = trial >= {1'b0, in_den};
      diff   = trial - {1'b0, in_den};
      rem_in = ge ? diff[DenW-1:0] : trial[DenW-1:0];
      num_in = {in_num[QuoW-2:0], 1'b0};
      quo_in = {in_quo[QuoW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         num_ff <= num_in;
         quo_ff <= quo_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_pay   = pay_ff;

endmodule

FILE: rtl/baa_sqrt_cell.sv
// One square root cell: yields one root bit per cycle while en is high, from two radicand bits.
// Depends on baa_pkg.
`timescale 1ns / 1ps

module baa_sqrt_cell
   import baa_pkg::*;
#(
   parameter int PW = 1
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RadW-1:0]   in_rad,
   input  logic [SqRemW-1:0] in_rem,
   input  logic [RootW-1:0]  in_root,
   input  logic [PW-1:0]     in_pay,
   output logic              out_valid,
   output logic [RadW-1:0]   out_rad,
   output logic [SqRemW-1:0] out_rem,
   output logic [RootW-1:0]  out_root,
   output logic [PW-1:0]     out_pay
);

   logic              valid_ff;
   logic [RadW-1:0]   rad_ff, rad_in;
   logic [SqRemW-1:0] rem_ff, rem_in;
   logic [RootW-1:0]  root_ff, root_in;
   logic [PW-1:0]     pay_ff;
   logic [SqRemW+1:0] trial, tst, diff;
   logic              ge;

   always_comb begin
      trial   = {in_rem, in_rad[RadW-1 -: 2]};
      tst     = (SqRemW+2)'({in_root, 2'b01});
      ge      = trial >= tst;
      diff    = trial - tst;
      rem_in  = ge ? diff[SqRemW-1:0] : trial[SqRemW-1:0];
      root_in = {in_root[RootW-2:0], ge};
      rad_in  = {in_rad[RadW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pay_ff  <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_pay   = pay_ff;

endmodule

FILE: rtl/baa_norm_cell.sv
// Two-stage normalizer that scales a vector so its larger part lies in [2^29, 2^30).
// Depends on baa_pkg.
`timescale 1ns / 1ps

module baa_norm_cell
   import baa_pkg::*;
#(
   parameter int PW = 1
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [MagW-1:0] in_a,
   input  logic [MagW-1:0] in_b,
   input  logic [PW-1:0]   in_pay,
   output logic            out_valid,
   output logic [NrmW-1:0] out_a,
   output logic [NrmW-1:0] out_b,
   output logic [PW-1:0]   out_pay
);

   logic                 v1_ff, v2_ff;
   logic [MagW-1:0]      a1_ff, b1_ff, m;
   logic [LenW-1:0]      len_ff, len_in;
   logic [PW-1:0]        p1_ff, p2_ff;
   logic [NrmW-1:0]      a2_ff, b2_ff;
   logic [MagW+NrmW-1:0] wa, wb;

   always_comb begin
      m      = in_a | in_b;
      len_in = '0;
      for (int i = 0; i < MagW; i++) begin
         if (m[i]) begin
            len_in = LenW'(i + 1);
         end
      end
      wa = {a1_ff, NrmW'(0)} >> len_ff;
      wb = {b1_ff, NrmW'(0)} >> len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= in_a;
         b1_ff  <= in_b;
         len_ff <= len_in;
         p1_ff  <= in_pay;
         a2_ff  <= wa[NrmW-1:0];
         b2_ff  <= wb[NrmW-1:0];
         p2_ff  <= p1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_a     = a2_ff;
   assign out_b     = b2_ff;
   assign out_pay   = p2_ff;

endmodule

FILE: rtl/baa_cordic_cell.sv
// One vectoring CORDIC iteration with a fixed shift and table angle.
// Depends on baa_pkg.
`timescale 1ns / 1ps

module baa_cordic_cell
   import baa_pkg::*;
#(
   parameter int STEP = 0,
   parameter int PW   = 1
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [CxW-1:0] in_x,
   input  logic signed [CxW-1:0] in_y,
   input  logic signed [CaW-1:0] in_z,
   input  logic [PW-1:0]         in_pay,
   output logic                  out_valid,
   output logic signed [CxW-1:0] out_x,
   output logic signed [CxW-1:0] out_y,
   output logic signed [CaW-1:0] out_z,
   output logic [PW-1:0]         out_pay
);

   logic                  valid_ff;
   logic signed [CxW-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [CaW-1:0] z_ff, z_in, ang;
   logic [PW-1:0]         pay_ff;

   always_comb begin
      dx  = in_y >>> STEP;
      dy  = in_x >>> STEP;
      ang = $signed(AtanTab[STEP]);
      if (!in_y[CxW-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ang;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         pay_ff <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_pay   = pay_ff;

endmodule

FILE: rtl/ballistic_aim_angles_core.sv
// Top level of the ballistic aim angle core.
// Uses baa_pkg, baa_div_cell, baa_sqrt_cell, baa_norm_cell and baa_cordic_cell.
`timescale 1ns / 1ps

// The core accepts one request per clock while req_tready is high and returns one
// response per request, in order. The chain is fully pipelined: 37 restoring division
// cells for the gravity drop, 31 square root cells for the barrel offset correction and
// CORDIC_STEPS cells in each of three CORDIC lanes, plus the arithmetic stages s1 to s7,
// the normalizers, the f1 stage and the output register. The whole chain holds only when
// a response waits in the output register and another one is ready behind it.
module ballistic_aim_angles_core
   import baa_pkg::*;
#(
   parameter int CORDIC_STEPS = CordicStepsDef
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x, pos_y, pos_z, shot_speed, zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // yaw_angle, pitch_angle, zero fill
   output logic [39:0] rsp_tdata,
   // status
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [OffW-1:0] csr_data
);

   localparam int DivPayW = 3 * PosW + 1;
   localparam int SqPayW  = MagW + 1 + ZmW + PosW + 1 + 1 + OffW;
   localparam int NLanes  = 3;
   localparam int LaneAl  = 0;
   localparam int LaneTh  = 1;
   localparam int LaneYw  = 2;

   logic                   adv;
   logic [OffW-1:0]        offset_ff;

   logic signed [PosW-1:0] in_x, in_y, in_z;
   logic [SpdW-1:0]        in_spd;

   logic                   s1_valid_ff;
   logic [PosW-1:0]        s1_x_ff, s1_y_ff, s1_z_ff;
   logic                   s1_badz_ff, s1_slow_ff;
   logic [Z2W-1:0]         s1_z2_ff;
   logic [S2W-1:0]         s1_s2_ff;

   logic                   s2_valid_ff;
   logic [NumW-1:0]        s2_num_ff, s2_num_in;
   logic [DenW-1:0]        s2_den_ff, s2_den_in;
   logic [DivPayW-1:0]     s2_pay_ff;

   logic                   dv_valid [QuoW+1];
   logic [DenW-1:0]        dv_rem [QuoW+1];
   logic [DenW-1:0]        dv_den [QuoW+1];
   logic [QuoW-1:0]        dv_num [QuoW+1];
   logic [QuoW-1:0]        dv_quo [QuoW+1];
   logic [DivPayW-1:0]     dv_pay [QuoW+1];

   logic [PosW-1:0]        dq_x, dq_y, dq_z;
   logic                   dq_badz;
   logic signed [YpW-1:0]  yp;

   logic                   s3_valid_ff;
   logic [MagW-1:0]        s3_uy_ff, s3_uy_in;
   logic                   s3_ys_ff, s3_xs_ff, s3_badz_ff;
   logic [ZmW-1:0]         s3_z_ff;
   logic [PosW-1:0]        s3_ux_ff, s3_ux_in;

   logic [KW-1:0]          s4_k;
   logic                   s4_valid_ff;
   logic [NrmW-1:0]        s4_ysh_ff;
   logic [ZmW-1:0]         s4_zsh_ff;
   logic [OffW-1:0]        s4_off_ff;
   logic [MagW-1:0]        s4_uy_ff;
   logic                   s4_ys_ff, s4_xs_ff, s4_badz_ff;
   logic [ZmW-1:0]         s4_z_ff;
   logic [PosW-1:0]        s4_ux_ff;

   logic                   s5_valid_ff;
   logic [YsqW-1:0]        s5_ysq_ff;
   logic [Z2W-1:0]         s5_zsq_ff;
   logic [2*OffW-1:0]      s5_off2_ff;
   logic [OffW-1:0]        s5_off_ff;
   logic [MagW-1:0]        s5_uy_ff;
   logic                   s5_ys_ff, s5_xs_ff, s5_badz_ff;
   logic [ZmW-1:0]         s5_z_ff;
   logic [PosW-1:0]        s5_ux_ff;

   logic                   s6_valid_ff;
   logic [R2W-1:0]         s6_r2_ff;
   logic [2*OffW-1:0]      s6_off2_ff;
   logic [OffW-1:0]        s6_off_ff;
   logic [MagW-1:0]        s6_uy_ff;
   logic                   s6_ys_ff, s6_xs_ff, s6_badz_ff;
   logic [ZmW-1:0]         s6_z_ff;
   logic [PosW-1:0]        s6_ux_ff;

   logic                   s7_valid_ff;
   logic [RadW-1:0]        s7_rad_ff;
   logic [SqPayW-1:0]      s7_pay_ff;

   logic                   sq_valid [RootW+1];
   logic [RadW-1:0]        sq_rad [RootW+1];
   logic [SqRemW-1:0]      sq_rem [RootW+1];
   logic [RootW-1:0]       sq_root [RootW+1];
   logic [SqPayW-1:0]      sq_pay [RootW+1];

   logic [MagW-1:0]        fq_uy;
   logic                   fq_ys, fq_xs, fq_err;
   logic [ZmW-1:0]         fq_z;
   logic [PosW-1:0]        fq_ux;
   logic [OffW-1:0]        fq_off;

   logic [MagW-1:0]        ln_a [NLanes];
   logic [MagW-1:0]        ln_b [NLanes];
   logic                   ln_p [NLanes];
   logic                   nm_valid [NLanes];
   logic [NrmW-1:0]        nm_a [NLanes];
   logic [NrmW-1:0]        nm_b [NLanes];
   logic                   nm_p [NLanes];

   logic                   cd_valid [NLanes][CORDIC_STEPS+1];
   logic signed [CxW-1:0]  cd_x [NLanes][CORDIC_STEPS+1];
   logic signed [CxW-1:0]  cd_y [NLanes][CORDIC_STEPS+1];
   logic signed [CaW-1:0]  cd_z [NLanes][CORDIC_STEPS+1];
   logic                   cd_p [NLanes][CORDIC_STEPS+1];

   logic signed [CaW-1:0]  clamp [NLanes];
   logic                   f1_valid_ff;
   logic signed [CaW-1:0]  f1_yaw_ff, f1_th_ff, f1_al_ff;
   logic                   f1_err_ff;

   logic signed [CaW-1:0]  pitch_fine, yaw_rnd, pitch_rnd;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AngW-1:0]        rsp_yaw_ff, rsp_pitch_ff;
   logic                   rsp_status_ff;

   assign adv        = !(rsp_valid_ff && !rsp_tready && f1_valid_ff);
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_valid) begin
         offset_ff <= csr_data;
      end
   end

   // Stage 1: squares of the forward distance and the speed.
   assign in_x   = req_tdata[PosW-1:0];
   assign in_y   = req_tdata[2*PosW-1:PosW];
   assign in_z   = req_tdata[3*PosW-1:2*PosW];
   assign in_spd = req_tdata[3*PosW+SpdW-1:3*PosW];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff    <= in_x;
         s1_y_ff    <= in_y;
         s1_z_ff    <= in_z;
         s1_badz_ff <= in_z <= 0;
         s1_slow_ff <= in_spd <= SpdW'(SlowSpd);
         s1_z2_ff   <= Z2W'(in_z[ZmW-1:0]) * Z2W'(in_z[ZmW-1:0]);
         s1_s2_ff   <= S2W'(in_spd) * S2W'(in_spd);
      end
   end

   // Stage 2: rounded drop numerator and denominator.
   always_comb begin
      if (s1_slow_ff) begin
         s2_num_in = '0;
         s2_den_in = DenW'(1);
      end else begin
         s2_num_in = NumW'(s1_z2_ff) * NumW'(DropNumK) + NumW'(s1_s2_ff) * NumW'(DropBiasK);
         s2_den_in = DenW'(s1_s2_ff) * DenW'(DropDenK);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_num_ff <= s2_num_in;
         s2_den_ff <= s2_den_in;
         s2_pay_ff <= {s1_x_ff, s1_y_ff, s1_z_ff, s1_badz_ff};
      end
   end

   assign dv_valid[0] = s2_valid_ff;
   assign dv_rem[0]   = DenW'(s2_num_ff[NumW-1:QuoW]);
   assign dv_den[0]   = s2_den_ff;
   assign dv_num[0]   = s2_num_ff[QuoW-1:0];
   assign dv_quo[0]   = '0;
   assign dv_pay[0]   = s2_pay_ff;

   for (genvar i = 0; i < QuoW; i++) begin : g_div
      baa_div_cell #(.PW(DivPayW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (dv_valid[i]),
         .in_rem   (dv_rem[i]),
         .in_den   (dv_den[i]),
         .in_num   (dv_num[i]),
         .in_quo   (dv_quo[i]),
         .in_pay   (dv_pay[i]),
         .out_valid(dv_valid[i+1]),
         .out_rem  (dv_rem[i+1]),
         .out_den  (dv_den[i+1]),
         .out_num  (dv_num[i+1]),
         .out_quo  (dv_quo[i+1]),
         .out_pay  (dv_pay[i+1])
      );
   end

   // Stage 3: corrected height and magnitudes.
   assign {dq_x, dq_y, dq_z, dq_badz} = dv_pay[QuoW];

   always_comb begin
      yp       = $signed({{(YpW-PosW){dq_y[PosW-1]}}, dq_y}) - $signed({1'b0, dv_quo[QuoW]});
      s3_uy_in = yp[YpW-1] ? MagW'(-yp) : MagW'(yp);
      s3_ux_in = dq_x[PosW-1] ? PosW'(-$signed(dq_x)) : dq_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= dv_valid[QuoW];
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_comb begin
      s4_k = '0;
      for (int i = NrmW; i < MagW; i++) begin
         if (s3_uy_ff[i]) begin
            s4_k = KW'(i - NrmW + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_uy_ff   <= s3_uy_in;
         s3_ys_ff   <= yp[YpW-1];
         s3_xs_ff   <= dq_x[PosW-1];
         s3_badz_ff <= dq_badz;
         s3_z_ff    <= dq_z[ZmW-1:0];
         s3_ux_ff   <= s3_ux_in;

         s4_ysh_ff  <= NrmW'(s3_uy_ff >> s4_k);
         s4_zsh_ff  <= s3_z_ff >> s4_k;
         s4_off_ff  <= offset_ff >> s4_k;
         s4_uy_ff   <= s3_uy_ff;
         s4_ys_ff   <= s3_ys_ff;
         s4_xs_ff   <= s3_xs_ff;
         s4_badz_ff <= s3_badz_ff;
         s4_z_ff    <= s3_z_ff;
         s4_ux_ff   <= s3_ux_ff;

         s5_ysq_ff  <= YsqW'(s4_ysh_ff) * YsqW'(s4_ysh_ff);
         s5_zsq_ff  <= Z2W'(s4_zsh_ff) * Z2W'(s4_zsh_ff);
         s5_off2_ff <= (2*OffW)'(s4_off_ff) * (2*OffW)'(s4_off_ff);
         s5_off_ff  <= s4_off_ff;
         s5_uy_ff   <= s4_uy_ff;
         s5_ys_ff   <= s4_ys_ff;
         s5_xs_ff   <= s4_xs_ff;
         s5_badz_ff <= s4_badz_ff;
         s5_z_ff    <= s4_z_ff;
         s5_ux_ff   <= s4_ux_ff;

         s6_r2_ff   <= R2W'(s5_ysq_ff) + R2W'(s5_zsq_ff);
         s6_off2_ff <= s5_off2_ff;
         s6_off_ff  <= s5_off_ff;
         s6_uy_ff   <= s5_uy_ff;
         s6_ys_ff   <= s5_ys_ff;
         s6_xs_ff   <= s5_xs_ff;
         s6_badz_ff <= s5_badz_ff;
         s6_z_ff    <= s5_z_ff;
         s6_ux_ff   <= s5_ux_ff;

         s7_rad_ff  <= RadW'(s6_r2_ff - R2W'(s6_off2_ff));
         s7_pay_ff  <= {s6_uy_ff, s6_ys_ff, s6_z_ff, s6_ux_ff, s6_xs_ff,
                        s6_badz_ff || (R2W'(s6_off2_ff) > s6_r2_ff), s6_off_ff};
      end
   end

   assign sq_valid[0] = s7_valid_ff;
   assign sq_rad[0]   = s7_rad_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_pay[0]   = s7_pay_ff;

   for (genvar i = 0; i < RootW; i++) begin : g_sqrt
      baa_sqrt_cell #(.PW(SqPayW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (sq_valid[i]),
         .in_rad   (sq_rad[i]),
         .in_rem   (sq_rem[i]),
         .in_root  (sq_root[i]),
         .in_pay   (sq_pay[i]),
         .out_valid(sq_valid[i+1]),
         .out_rad  (sq_rad[i+1]),
         .out_rem  (sq_rem[i+1]),
         .out_root (sq_root[i+1]),
         .out_pay  (sq_pay[i+1])
      );
   end

   assign {fq_uy, fq_ys, fq_z, fq_ux, fq_xs, fq_err, fq_off} = sq_pay[RootW];

   assign ln_a[LaneAl] = MagW'(fq_off);
   assign ln_b[LaneAl] = MagW'(sq_root[RootW]);
   assign ln_p[LaneAl] = fq_err;
   assign ln_a[LaneTh] = fq_uy;
   assign ln_b[LaneTh] = MagW'(fq_z);
   assign ln_p[LaneTh] = fq_ys;
   assign ln_a[LaneYw] = MagW'(fq_ux);
   assign ln_b[LaneYw] = MagW'(fq_z);
   assign ln_p[LaneYw] = fq_xs;

   for (genvar l = 0; l < NLanes; l++) begin : g_lane
      baa_norm_cell #(.PW(1)) u_norm (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (sq_valid[RootW]),
         .in_a     (ln_a[l]),
         .in_b     (ln_b[l]),
         .in_pay   (ln_p[l]),
         .out_valid(nm_valid[l]),
         .out_a    (nm_a[l]),
         .out_b    (nm_b[l]),
         .out_pay  (nm_p[l])
      );

      assign cd_valid[l][0] = nm_valid[l];
      assign cd_x[l][0]     = $signed(CxW'(nm_b[l]));
      assign cd_y[l][0]     = $signed(CxW'(nm_a[l]));
      assign cd_z[l][0]     = '0;
      assign cd_p[l][0]     = nm_p[l];

      for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
         baa_cordic_cell #(.STEP(s), .PW(1)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .en       (adv),
            .in_valid (cd_valid[l][s]),
            .in_x     (cd_x[l][s]),
            .in_y     (cd_y[l][s]),
            .in_z     (cd_z[l][s]),
            .in_pay   (cd_p[l][s]),
            .out_valid(cd_valid[l][s+1]),
            .out_x    (cd_x[l][s+1]),
            .out_y    (cd_y[l][s+1]),
            .out_z    (cd_z[l][s+1]),
            .out_pay  (cd_p[l][s+1])
         );
      end

      always_comb begin
         if (cd_z[l][CORDIC_STEPS] < 0) begin
            clamp[l] = '0;
         end else if (cd_z[l][CORDIC_STEPS] > AngMax) begin
            clamp[l] = AngMax;
         end else begin
            clamp[l] = cd_z[l][CORDIC_STEPS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= cd_valid[LaneAl][CORDIC_STEPS] && cd_valid[LaneTh][CORDIC_STEPS]
                        && cd_valid[LaneYw][CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_al_ff  <= clamp[LaneAl];
         f1_th_ff  <= cd_p[LaneTh][CORDIC_STEPS] ? -clamp[LaneTh] : clamp[LaneTh];
         f1_yaw_ff <= cd_p[LaneYw][CORDIC_STEPS] ? -clamp[LaneYw] : clamp[LaneYw];
         f1_err_ff <= cd_p[LaneAl][CORDIC_STEPS];
      end
   end

   // Output register: pitch difference and rounding to 1/256 degree.
   always_comb begin
      pitch_fine   = f1_th_ff - f1_al_ff;
      yaw_rnd      = (f1_yaw_ff + CaW'(RoundBias)) >>> RoundShift;
      pitch_rnd    = (pitch_fine + CaW'(RoundBias)) >>> RoundShift;
      rsp_valid_in = f1_valid_ff || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && f1_valid_ff) begin
         rsp_yaw_ff    <= f1_err_ff ? '0 : yaw_rnd[AngW-1:0];
         rsp_pitch_ff  <= f1_err_ff ? '0 : pitch_rnd[AngW-1:0];
         rsp_status_ff <= f1_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_pitch_ff, rsp_yaw_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("error response carries nonzero angles");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && f1_valid_ff)
      else $error("pipeline held without a waiting response");

   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[16:0]) >= -17'sd46080
                     && $signed(rsp_tdata[16:0]) <= 17'sd46080)
      else $error("yaw out of range");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[33:17]) >= -17'sd46080
                     && $signed(rsp_tdata[33:17]) <= 17'sd46080)
      else $error("pitch out of range");
`endif

endmodule
